FILE: design/velocity_max_magnitude_dilation_defines.svh
// Assertion macros of the dilation block.
`ifndef VELOCITY_MAX_MAGNITUDE_DILATION_DEFINES_SVH
`define VELOCITY_MAX_MAGNITUDE_DILATION_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define VMD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define VMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/vmd_pkg.sv
// Package of the dilation block: widths, cell data, control and state types.
`timescale 1ns / 1ps
package vmd_pkg;

	localparam int VEL_W = 16;
	localparam int VEC_W = 2 * VEL_W;
	localparam int MAG_W = 32;

	localparam int MAX_RADIUS_DEF = 32;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;

	// One stored vector together with its squared magnitude
	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic [VEC_W-1:0] vec;
	} cell_t;

	// Control of the row chain: load a new pixel or rotate the ring
	typedef struct packed {
		logic shift;
		logic rot;
	} chain_ctrl_t;

	typedef enum logic [1:0] {
		REG_RADIUS,
		REG_WIDTH,
		REG_HEIGHT
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_HSCAN,
		ST_VSCAN,
		ST_STORE
	} vmd_state_t;

	// Exact squared magnitude of a Q10.6 vector, at most 2^31
	function automatic logic [MAG_W-1:0] mag_of(input logic [VEC_W-1:0] v);
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
		logic signed [MAG_W-1:0] px;
		logic signed [MAG_W-1:0] py;
		vx = v[VEL_W-1:0];
		vy = v[VEC_W-1:VEL_W];
		px = MAG_W'(vx) * MAG_W'(vx);
		py = MAG_W'(vy) * MAG_W'(vy);
		return $unsigned(px) + $unsigned(py);
	endfunction

endpackage

FILE: design/vmd_stream_if.sv
// Stream interfaces of the dilation block: vector input and dilated output.
`timescale 1ns / 1ps
interface vmd_in_if;
	import vmd_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    cmd;
	logic signed [VEL_W-1:0] vel_x;
	logic signed [VEL_W-1:0] vel_y;

	modport source (output valid, cmd, vel_x, vel_y, input ready);
	modport sink   (input valid, cmd, vel_x, vel_y, output ready);
endinterface

interface vmd_out_if;
	import vmd_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VEL_W-1:0] dil_x;
	logic signed [VEL_W-1:0] dil_y;
	logic                    last_of_run;
	logic                    last_of_frame;

	modport source (output valid, dil_x, dil_y, last_of_run, last_of_frame, input ready);
	modport sink   (input valid, dil_x, dil_y, last_of_run, last_of_frame, output ready);
endinterface

FILE: design/vmd_cell.sv
// One cell of the row chain: holds a pixel and its magnitude.
`timescale 1ns / 1ps
module vmd_cell (
	input  logic                 clk,
	input  vmd_pkg::chain_ctrl_t ctrl,
	input  vmd_pkg::cell_t       left,
	input  vmd_pkg::cell_t       right,
	output vmd_pkg::cell_t       q
);
	import vmd_pkg::*;

	cell_t data_q;

	// Take the left neighbour on a shift, the right one on a rotation
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= left;
		end else if (ctrl.rot) begin
			data_q <= right;
		end
	end

	assign q = data_q;

endmodule

FILE: design/vmd_row_chain.sv
// Row chain: the most recent pixels of a row, shifted in and rotated past a tap.
`timescale 1ns / 1ps
module vmd_row_chain #(
	parameter int N = 2 * vmd_pkg::MAX_RADIUS_DEF + 1
) (
	input  logic                 clk,
	input  vmd_pkg::chain_ctrl_t ctrl,
	input  vmd_pkg::cell_t       din,
	output vmd_pkg::cell_t       tap
);
	import vmd_pkg::*;

	cell_t cq [N];

	// Cell 0 holds the newest pixel; a rotation brings older ones to it
	for (genvar k = 0; k < N; k++) begin : g_cell
		if (k == 0 && k == N - 1) begin : g_one
			vmd_cell u_cell (.clk(clk), .ctrl(ctrl), .left(din), .right(cq[0]), .q(cq[k]));
		end else if (k == 0) begin : g_first
			vmd_cell u_cell (.clk(clk), .ctrl(ctrl), .left(din), .right(cq[1]), .q(cq[k]));
		end else if (k == N - 1) begin : g_last
			vmd_cell u_cell (.clk(clk), .ctrl(ctrl), .left(cq[k-1]), .right(cq[0]), .q(cq[k]));
		end else begin : g_mid
			vmd_cell u_cell (.clk(clk), .ctrl(ctrl), .left(cq[k-1]), .right(cq[k+1]),
				.q(cq[k]));
		end
	end

	assign tap = cq[0];

endmodule

FILE: design/vmd_line_mem.sv
// Line memory of row maxima: one write port, one registered read port.
`timescale 1ns / 1ps
module vmd_line_mem #(
	parameter int AW = 16,
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	// Write row maxima
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/velocity_max_magnitude_dilation.sv
// Max-magnitude dilation of a motion vector stream, row pass then column pass.
//
// Each accepted pixel shifts into a chain of 2*MAX_RADIUS+1 cells. An item that
// completes no column leaves the block idle and ready for the next. For every
// column that it completes the block passes a setup state, rotates the row chain
// past its tap through all its cells for the row maximum (skipped on padding rows),
// reads the rows of the column window one by one from the line memory (up to 2R),
// and stores the result and hands it over once the output register is free. The
// rotating chain and the single read port of the line memory take most of the
// time per result. New items are taken only once all results of the previous one
// are produced; the last result may still wait in the output register. The line
// memory needs no clearing pass. Outputs lag by R rows, and the sender appends R
// rows of padding beats to flush the end of the frame.
`timescale 1ns / 1ps
`include "velocity_max_magnitude_dilation_defines.svh"
module velocity_max_magnitude_dilation #(
	parameter int MAX_RADIUS = vmd_pkg::MAX_RADIUS_DEF,
	parameter int MAX_WIDTH  = vmd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = vmd_pkg::MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	vmd_in_if.sink      vec_in,
	vmd_out_if.source   dil_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import vmd_pkg::*;

	localparam int RING = 2 * MAX_RADIUS;
	localparam int SW   = $clog2(RING);
	localparam int L    = 2 * MAX_RADIUS + 1;
	localparam int KW   = $clog2(L);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int PW   = $clog2(MAX_HEIGHT + MAX_WIDTH + 2 * MAX_RADIUS + 2) + 1;
	localparam int AW   = SW + CW;

	// Configuration registers
	logic [5:0]  radius_q;
	logic [10:0] width_q;
	logic [12:0] height_q;

	logic [PW-1:0] r_eff, w_eff, h_eff;

	// Position and sequencing
	vmd_state_t    state_q, state_d;
	logic [PW-1:0] col_q, row_q;
	logic [SW-1:0] slot_q;
	logic [PW-1:0] x_q, r_q, c_q, cend_q;
	logic [SW-1:0] rslot_q, qslot_q;
	logic [PW-1:0] klo_q, khi_q, vcnt_q;
	logic [KW-1:0] k_q;
	logic          emit_q;
	cell_t         hm_q, vbest_q;
	logic          rd_vld_s1;

	// Output register
	logic             out_valid_q;
	logic [VEC_W-1:0] out_vec_q;
	logic             out_lor_q, out_lof_q;

	// Handshakes and control
	logic        in_fire, cfg_we, cfg_hit, adv, out_load, mem_we, rd_en;
	cfg_reg_t    cfg_idx;
	chain_ctrl_t ctrl;
	cell_t       new_cell, tap, rd_cell, final_cell;
	logic [$bits(cell_t)-1:0] rd_raw;

	// Values of the accepted beat
	logic          wrap;
	logic [PW-1:0] x_in, r_in;
	logic [SW-1:0] s_in;
	logic [VEC_W-1:0] v_in;

	// Column window bounds
	logic [PW-1:0] hlo, hhi, o_row, vlo, vtop, vd;
	logic          has_cols;

	// Effective settings, saturated to the supported range
	always_comb begin
		r_eff = (PW'(radius_q) > PW'(MAX_RADIUS)) ? PW'(MAX_RADIUS) : PW'(radius_q);
		if (width_q == 11'd0) begin
			w_eff = PW'(1);
		end else if (PW'(width_q) > PW'(MAX_WIDTH)) begin
			w_eff = PW'(MAX_WIDTH);
		end else begin
			w_eff = PW'(width_q);
		end
		if (height_q == 13'd0) begin
			h_eff = PW'(1);
		end else if (PW'(height_q) > PW'(MAX_HEIGHT)) begin
			h_eff = PW'(MAX_HEIGHT);
		end else begin
			h_eff = PW'(height_q);
		end
	end

	// Configuration port
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = cfg_reg_t'(paddr[3:2]);

	always_comb begin
		case (cfg_idx)
			REG_RADIUS: cfg_hit = cfg_we;
			REG_WIDTH:  cfg_hit = cfg_we;
			REG_HEIGHT: cfg_hit = cfg_we;
			default:    cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 6'd32;
			width_q  <= 11'd1024;
			height_q <= 13'd1024;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_RADIUS: radius_q <= pwdata[5:0];
				REG_WIDTH:  width_q  <= pwdata[10:0];
				REG_HEIGHT: height_q <= pwdata[12:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_RADIUS: prdata = 32'(radius_q);
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			default:    prdata = '0;
		endcase
	end

	// Position of the accepted beat, restarting after the last padding row
	always_comb begin
		wrap = (col_q >= w_eff) || (row_q >= h_eff + r_eff);
		x_in = wrap ? '0 : col_q;
		r_in = wrap ? '0 : row_q;
		s_in = wrap ? '0 : slot_q;
		v_in = (!vec_in.cmd && r_in < h_eff) ? {vec_in.vel_y, vec_in.vel_x} : '0;
		has_cols = (x_in >= r_eff) || (x_in == w_eff - PW'(1));
		new_cell.mag = mag_of(v_in);
		new_cell.vec = v_in;
	end

	// Window bounds of the current column
	always_comb begin
		hlo   = (c_q > r_eff) ? c_q - r_eff : '0;
		hhi   = (c_q + r_eff < w_eff - PW'(1)) ? c_q + r_eff : w_eff - PW'(1);
		o_row = r_q - r_eff;
		vlo   = (o_row > r_eff) ? o_row - r_eff : '0;
		vtop  = (r_q < h_eff) ? r_q : h_eff;
		vd    = r_q - vlo;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && has_cols) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_d = (r_q < h_eff) ? ST_HSCAN : ST_VSCAN;
			end
			ST_HSCAN: begin
				if (k_q == KW'(L - 1)) begin
					state_d = ST_VSCAN;
				end
			end
			ST_VSCAN: begin
				if (vcnt_q == '0 && !rd_vld_s1) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				if (adv) begin
					state_d = (c_q == cend_q) ? ST_IDLE : ST_SETUP;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		vec_in.ready = (state_q == ST_IDLE);
		in_fire      = vec_in.valid && (state_q == ST_IDLE);
		ctrl.shift   = in_fire;
		ctrl.rot     = (state_q == ST_HSCAN);
		rd_en        = (state_q == ST_VSCAN) && (vcnt_q != '0);
		adv          = (state_q == ST_STORE) && (!emit_q || !out_valid_q || dil_out.ready);
		out_load     = adv && emit_q;
		mem_we       = adv && (r_q < h_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Stream position counters; a register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (cfg_hit) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (in_fire) begin
			if (x_in + PW'(1) >= w_eff) begin
				col_q <= '0;
				if (r_in + PW'(1) >= h_eff + r_eff) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= r_in + PW'(1);
					slot_q <= (s_in == SW'(RING - 1)) ? '0 : s_in + SW'(1);
				end
			end else begin
				col_q  <= x_in + PW'(1);
				row_q  <= r_in;
				slot_q <= s_in;
			end
		end
	end

	// Column sequencing and the two maximum searches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			vcnt_q    <= '0;
			rd_vld_s1 <= 1'b0;
			emit_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						x_q     <= x_in;
						r_q     <= r_in;
						rslot_q <= s_in;
						c_q     <= (x_in >= r_eff) ? x_in - r_eff : '0;
						cend_q  <= (x_in == w_eff - PW'(1)) ? w_eff - PW'(1) : x_in - r_eff;
					end
				end
				ST_SETUP: begin
					klo_q   <= x_q - hhi;
					khi_q   <= x_q - hlo;
					k_q     <= '0;
					hm_q    <= '0;
					vbest_q <= '0;
					emit_q  <= (r_q >= r_eff);
					vcnt_q  <= (r_q >= r_eff) ? vtop - vlo : '0;
					qslot_q <= (rslot_q >= SW'(vd)) ? rslot_q - SW'(vd)
						: SW'(PW'(rslot_q) + PW'(RING) - vd);
				end
				ST_HSCAN: begin
					// Scan right to left; ties go to the leftmost pixel
					if (PW'(k_q) >= klo_q && PW'(k_q) <= khi_q && tap.mag >= hm_q.mag) begin
						hm_q <= tap;
					end
					k_q <= k_q + KW'(1);
				end
				ST_VSCAN: begin
					if (rd_en) begin
						vcnt_q  <= vcnt_q - PW'(1);
						qslot_q <= (qslot_q == SW'(RING - 1)) ? '0 : qslot_q + SW'(1);
					end
					// Scan top to bottom; ties go to the topmost row
					if (rd_vld_s1 && rd_cell.mag > vbest_q.mag) begin
						vbest_q <= rd_cell;
					end
				end
				ST_STORE: begin
					if (adv && c_q != cend_q) begin
						c_q <= c_q + PW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Current row closes the column window
	assign final_cell = (r_q < h_eff && hm_q.mag > vbest_q.mag) ? hm_q : vbest_q;

	// Row chain and line memory
	vmd_row_chain #(.N(L)) u_chain (
		.clk(clk), .ctrl(ctrl), .din(new_cell), .tap(tap)
	);

	vmd_line_mem #(.AW(AW), .DW($bits(cell_t))) u_lines (
		.clk(clk),
		.we(mem_we),
		.waddr({rslot_q, c_q[CW-1:0]}),
		.wdata(hm_q),
		.re(rd_en),
		.raddr({qslot_q, c_q[CW-1:0]}),
		.rdata(rd_raw)
	);

	assign rd_cell = cell_t'(rd_raw);

	// Output register: hold a beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (dil_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_vec_q <= final_cell.vec;
			out_lor_q <= (c_q == cend_q);
			out_lof_q <= (o_row == h_eff - PW'(1)) && (c_q == w_eff - PW'(1));
		end
	end

	assign dil_out.valid         = out_valid_q;
	assign dil_out.dil_x         = out_vec_q[VEL_W-1:0];
	assign dil_out.dil_y         = out_vec_q[VEC_W-1:VEL_W];
	assign dil_out.last_of_run   = out_lor_q;
	assign dil_out.last_of_frame = out_lof_q;

	// Checks
	`VMD_ASSERT_NOW(a_full_rotation, (state_q == ST_HSCAN && state_d != ST_HSCAN), (k_q == KW'(L - 1)), "row chain left before a full rotation")
	`VMD_ASSERT_NOW(a_no_overwrite, out_load, (!out_valid_q || dil_out.ready), "pending result overwritten")
	`VMD_ASSERT_NOW(a_frame_end_run, (dil_out.valid && dil_out.last_of_frame), dil_out.last_of_run, "frame end not at end of run")
	`VMD_ASSERT_NEXT(a_run_done, (adv && c_q == cend_q), (state_q == ST_IDLE), "sequencer busy after last column")

endmodule

FILE: tb/sv/vmd_dilation_checker.sv
// Checker of the dilation block: tracks registers, predicts dilated vectors, compares beats.
`timescale 1ns / 1ps
module vmd_dilation_checker (
	input  logic        clk,
	input  logic        arst_n,
	vmd_in_if           vin,
	vmd_out_if          vout,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          errors,
	output int          pending,
	output int          checked
);
	import vmd_pkg::*;

	localparam int LIM_R = 32;
	localparam int LIM_W = 1024;
	localparam int LIM_H = 4096;
	localparam int RING  = 2 * LIM_R;

	typedef struct {
		logic [15:0] dx;
		logic [15:0] dy;
		logic        lor;
		logic        lof;
	} dil_beat_t;

	dil_beat_t   dil_due[$];
	logic [5:0]  cur_radius;
	logic [10:0] cur_width;
	logic [12:0] cur_height;
	logic [31:0] recent_px[RING];
	logic [31:0] hmax_lines[RING * LIM_W];
	int unsigned col_pos;
	int unsigned row_pos;

	assign pending = dil_due.size();

	function automatic longint unsigned sq_mag(input logic [31:0] p);
		longint a;
		longint b;
		a = longint'($signed(p[15:0]));
		b = longint'($signed(p[31:16]));
		return longint'(a * a + b * b);
	endfunction

	task automatic report(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		errors++;
	endtask

	// Work out every dilated vector that one accepted beat completes
	task automatic predict_dilation(input logic cmd, input logic [15:0] vx, input logic [15:0] vy);
		int unsigned rr, ww, hh, x, r, c, cs, ce, lo, hi, p, q, o;
		logic [31:0] v, hm, pv, qv, res;
		longint unsigned best, m;
		dil_beat_t   b;
		dil_beat_t   batch[$];
		rr = cur_radius > LIM_R ? LIM_R : cur_radius;
		ww = cur_width < 1 ? 1 : (cur_width > LIM_W ? LIM_W : cur_width);
		hh = cur_height < 1 ? 1 : (cur_height > LIM_H ? LIM_H : cur_height);
		if (col_pos >= ww || row_pos >= hh + rr) begin
			col_pos = 0;
			row_pos = 0;
		end
		x = col_pos;
		r = row_pos;
		v = (cmd == 1'b0 && r < hh) ? {vy, vx} : 32'h0;
		if (x >= rr || x == ww - 1) begin
			cs = x >= rr ? x - rr : 0;
			ce = x == ww - 1 ? ww - 1 : x - rr;
			for (c = cs; c <= ce; c++) begin
				hm = 32'h0;
				// row pass
				if (r < hh) begin
					best = 0;
					lo = c > rr ? c - rr : 0;
					hi = c + rr < ww - 1 ? c + rr : ww - 1;
					for (p = lo; p <= hi; p++) begin
						pv = (p == x) ? v : recent_px[p % RING];
						m = sq_mag(pv);
						if (m > best) begin
							best = m;
							hm = pv;
						end
					end
				end
				// column pass
				if (r >= rr && r - rr < hh) begin
					o = r - rr;
					lo = o > rr ? o - rr : 0;
					hi = r < hh - 1 ? r : hh - 1;
					best = 0;
					res = 32'h0;
					for (q = lo; q <= hi; q++) begin
						qv = (q == r) ? hm : hmax_lines[(q % RING) * LIM_W + c];
						m = sq_mag(qv);
						if (m > best) begin
							best = m;
							res = qv;
						end
					end
					b.dx = res[15:0];
					b.dy = res[31:16];
					b.lor = 1'b0;
					b.lof = (o == hh - 1 && c == ww - 1);
					batch = {batch, b};
				end
				if (r < hh)
					hmax_lines[(r % RING) * LIM_W + c] = hm;
			end
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].lor = 1'b1;
		foreach (batch[i])
			dil_due = {dil_due, batch[i]};
		recent_px[x % RING] = v;
		x++;
		if (x >= ww) begin
			x = 0;
			r++;
			if (r >= hh + rr)
				r = 0;
		end
		col_pos = x;
		row_pos = r;
	endtask

	always @(posedge clk or negedge arst_n) begin
		dil_beat_t e;
		if (!arst_n) begin
			cur_radius = 6'd32;
			cur_width  = 11'd1024;
			cur_height = 13'd1024;
			col_pos = 0;
			row_pos = 0;
			foreach (recent_px[i])
				recent_px[i] = 32'h0;
			dil_due.delete();
			errors  = 0;
			checked = 0;
		end else begin
			// register writes restart the frame
			if (psel && penable && pwrite && pready) begin
				case (cfg_reg_t'(paddr[3:2]))
					REG_RADIUS: cur_radius = pwdata[5:0];
					REG_WIDTH:  cur_width  = pwdata[10:0];
					REG_HEIGHT: cur_height = pwdata[12:0];
					default: ;
				endcase
				if (paddr[3:2] <= REG_HEIGHT) begin
					col_pos = 0;
					row_pos = 0;
				end
			end
			if (vin.valid && vin.ready)
				predict_dilation(vin.cmd, vin.vel_x, vin.vel_y);
			// compare each result beat with the oldest prediction
			if (vout.valid && vout.ready) begin
				checked++;
				if (dil_due.size() == 0) begin
					report("result beat with nothing predicted");
				end else begin
					e = dil_due.pop_front();
					if (vout.dil_x !== e.dx || vout.dil_y !== e.dy ||
						vout.last_of_run !== e.lor || vout.last_of_frame !== e.lof)
						report($sformatf("got (%0d,%0d) run %b frame %b, want (%0d,%0d) run %b frame %b",
							vout.dil_x, vout.dil_y, vout.last_of_run, vout.last_of_frame,
							$signed(e.dx), $signed(e.dy), e.lor, e.lof));
				end
			end
		end
	end
endmodule

FILE: tb/sv/tb_velocity_max_magnitude_dilation.sv
// Top of the dilation testbench: clock, reset, register writes, vector stimulus, verdict.
`timescale 1ns / 1ps
module tb_velocity_max_magnitude_dilation;
	import vmd_pkg::*;

	localparam int  SETTLE_CYC = 5000;
	localparam int  HOLD_CYC   = 3000;
	localparam longint CYC_LIMIT = 20000000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	int          errors, pending, checked;
	int          beats_sent;
	int          burst_left;
	int          phases;

	vmd_in_if  vin ();
	vmd_out_if vout ();

	velocity_max_magnitude_dilation dut (
		.clk(clk), .arst_n(arst_n), .vec_in(vin.sink), .dil_out(vout.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	vmd_dilation_checker chk (
		.clk(clk), .arst_n(arst_n), .vin(vin), .vout(vout),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.errors(errors), .pending(pending), .checked(checked)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watchdog: stop a hung run
	initial begin
		longint cyc;
		cyc = 0;
		while (cyc < CYC_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// Receiver: randomly chosen stall patterns, one long hold-off
	initial begin
		int mode;
		bit held;
		held = 0;
		vout.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			repeat (64) begin
				@(negedge clk);
				if (!held && beats_sent >= 150) begin
					held = 1;
					vout.ready = 1'b0;
					repeat (HOLD_CYC) @(negedge clk);
				end
				case (mode)
					0: vout.ready = 1'b1;
					1: vout.ready = $urandom_range(0, 1);
					2: vout.ready = ($urandom_range(0, 7) != 0);
					default: vout.ready = ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	task automatic reg_write(input cfg_reg_t idx, input logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = 4'(idx) << 2;
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// Offer one beat, idling between bursts
	task automatic send_beat(input logic cmd, input logic [15:0] vx, input logic [15:0] vy);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				vin.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		vin.valid = 1'b1;
		vin.cmd = cmd;
		vin.vel_x = vx;
		vin.vel_y = vy;
		@(posedge clk);
		while (!vin.ready) @(posedge clk);
		burst_left--;
		beats_sent++;
	endtask

	// Wait for every result, then for the block to finish trailing work
	task automatic settle();
		@(negedge clk);
		vin.valid = 1'b0;
		burst_left = 0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_vel();
		logic [15:0] ties[6] = '{16'h0040, 16'hFFC0, 16'h0000, 16'h8000, 16'h7FFF, 16'h0001};
		case ($urandom_range(0, 2))
			0: return 16'($urandom);
			1: return ties[$urandom_range(0, 5)];
			default: return 16'($urandom_range(0, 3)) - 16'd1;
		endcase
	endfunction

	// Set all three registers in random order, then stream whole frames
	task automatic run_phase(input int rad, input int wid, input int hgt, input int frames,
		input int noise);
		int order[3];
		int rr, ww, hh, j;
		logic cmd;
		settle();
		order = '{0, 1, 2};
		order.shuffle();
		foreach (order[i])
			case (order[i])
				0: reg_write(REG_RADIUS, rad);
				1: reg_write(REG_WIDTH, wid);
				default: reg_write(REG_HEIGHT, hgt);
			endcase
		rr = rad > 32 ? 32 : rad;
		ww = wid < 1 ? 1 : (wid > 1024 ? 1024 : wid);
		hh = hgt < 1 ? 1 : (hgt > 4096 ? 4096 : hgt);
		phases++;
		repeat (frames)
			for (j = 0; j < (hh + rr) * ww; j++) begin
				if (j < hh * ww)
					cmd = ($urandom_range(0, 99) < noise);
				else
					cmd = !($urandom_range(0, 99) < noise);
				send_beat(cmd, pick_vel(), pick_vel());
			end
	endtask

	initial begin
		logic [15:0] dx[12] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0040, 16'h0000, 16'h1234,
			16'hFFC0, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
		logic [15:0] dy[12] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0040, 16'h5678,
			16'h0000, 16'hFFC0, 16'h0000, 16'h7FFF, 16'h0000, 16'hFFFF};
		logic dcmd[12] = '{0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		vin.valid = 1'b0;
		vin.cmd = 1'b0;
		vin.vel_x = '0;
		vin.vel_y = '0;
		beats_sent = 0;
		burst_left = 0;
		phases = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: 3x3 frame, radius 1, extremes, ties, padding inside and after the frame
		reg_write(REG_RADIUS, 1);
		reg_write(REG_WIDTH, 3);
		reg_write(REG_HEIGHT, 3);
		foreach (dx[i])
			send_beat(dcmd[i], dx[i], dy[i]);
		phases++;

		// Extreme settings: saturated radius, zero width and height, passthrough,
		// widest window, and a tall column that wraps the line store
		run_phase(63, 0, 0, 2, 10);
		run_phase(0, 5, 1, 1, 10);
		run_phase(32, 2, 1, 1, 5);
		run_phase(0, 1, 8191 & 13'h0, 3, 20);
		run_phase(32, 1, 40, 1, 5);
		run_phase(5, 12, 1, 1, 5);

		// Random settings with small frames
		while (beats_sent < 400)
			run_phase($urandom_range(0, 3), $urandom_range(1, 12), $urandom_range(1, 6),
				$urandom_range(1, 2), $urandom_range(0, 10));

		settle();
		$display("Covered %0d phases, %0d input beats, %0d result beats checked",
			phases, beats_sent, checked);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
